[sv/ultrasonic_candidate_pair_fusion_core_assert.svh]
// Assertion macros for the candidate pair fusion block.
// Expects clk and arst_n in the scope of the using module.
`ifndef ULTRASONIC_CANDIDATE_PAIR_FUSION_CORE_ASSERT_SVH
`define ULTRASONIC_CANDIDATE_PAIR_FUSION_CORE_ASSERT_SVH

// same-cycle implication
`define UCPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ucpf_pkg.sv]
// Shared types and constants for the candidate pair fusion block.
// No dependencies.
package ucpf_pkg;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_A, ST_MUL_B, ST_ABSV, ST_SCORE, ST_CHECK,
		ST_VEL_A, ST_VEL_B, ST_VCHK, ST_DIV, ST_FINISH
	} state_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SCORE = 2'd1;
	localparam logic [1:0] STATUS_SPEED = 2'd2;

	localparam logic       REG_MAX_SPEED = 1'b0;
	localparam logic       REG_INIT_REF  = 1'b1;

	localparam int         SW = 58;   // pair score width
	localparam logic [SW-1:0] SCORE_LIMIT = 58'd42949672960000;

	localparam int         DVW = 32;  // divider dividend width
	localparam int         QW  = 26;  // divider quotient width
	localparam int         MW  = 29;  // reciprocal width
	// ceil(2^35 / 125): exact floor division by 125 for any 32 bit dividend
	localparam logic [MW-1:0] DIV_MAGIC = 29'd274877907;
	localparam int         DIV_SHIFT = 35;
	// bias that keeps the dividend positive: 125 * 2^24
	localparam logic signed [32:0] DIV_BIAS = 33'sd2097152000;
	localparam logic signed [51:0] HALF_DIV = 52'sd16384000;
	localparam logic signed [38:0] QUOT_OFFSET = 39'sd16777216;

	typedef struct packed {
		logic           start;
		logic [DVW-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [QW-1:0]  quotient;
	} div_rsp_t;

endpackage

[sv/ucpf_if.sv]
// Valid/ready channel interfaces for candidate requests and fusion results.
// No dependencies.
interface ucpf_in_if;
	logic               valid;
	logic               ready;
	logic               path;
	logic [1:0]         slot;
	logic signed [31:0] sound_term;
	logic [15:0]        correction_factor;
	logic [31:0]        match_score;
	logic signed [31:0] velocity;
	logic               last;

	modport source(output valid, path, slot, sound_term, correction_factor,
		match_score, velocity, last, input ready);
	modport sink(input valid, path, slot, sound_term, correction_factor,
		match_score, velocity, last, output ready);
endinterface

interface ucpf_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] velocity_first;
	logic signed [31:0] velocity_second;

	modport source(output valid, status, velocity_first, velocity_second, input ready);
	modport sink(input valid, status, velocity_first, velocity_second, output ready);
endinterface

[sv/ultrasonic_candidate_pair_fusion_core.sv]
// Candidate pair fusion: stores candidates, scores all pairs on a last request.
// A non-last request is stored and the block stays idle. A last request runs each pair
// through MUL_A, MUL_B, ABSV and SCORE on the shared multiplier, then CHECK, VEL_A, VEL_B,
// VCHK, the reference divide in DIV and FINISH (a failed check skips to FINISH); ready in IDLE.
// Reset clears control state, restores registers to defaults; stores undefined.
// Depends on ucpf_pkg, ucpf_if, ucpf_div and the assertion macro header.
`include "ultrasonic_candidate_pair_fusion_core_assert.svh"
module ultrasonic_candidate_pair_fusion_core
	import ucpf_pkg::*;
#(
	parameter int CANDIDATES_PER_PATH = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	ucpf_in_if.sink     in_ch,
	ucpf_out_if.source  out_ch
);

	localparam int C     = CANDIDATES_PER_PATH;
	localparam int DEPTH = 2 * C;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = (C > 1) ? $clog2(C) : 1;

	logic signed [31:0] sound_q [DEPTH];
	logic [15:0]        factor_q [DEPTH];
	logic [31:0]        score_q [DEPTH];
	logic signed [31:0] vel_q [DEPTH];

	logic [30:0]        max_speed_q;
	logic signed [31:0] ref_q;

	state_t st_q, st_d;

	logic [IW-1:0]      i_q, j_q, bi_q, bj_q;
	logic signed [48:0] a_q, b_q, va_q, vb_q;
	logic [50:0]        diff_q;
	logic signed [50:0] dev_q, dbest_q;
	logic [32:0]        msum_q;
	logic [SW-1:0]      best_q;
	logic [1:0]         status_q;
	logic signed [31:0] vf_q, vs_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic signed [31:0] out_vf_q, out_vs_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               accept;
	logic [AW-1:0]      wr_addr, ai, aj, abi, abj;
	logic signed [31:0] mul_x;
	logic [15:0]        mul_f;
	logic signed [48:0] prod;
	logic signed [46:0] ref15;
	logic [SW-1:0]      s_now;
	logic [50:0]        dev_abs;
	logic [37:0]        m25;
	logic               pair_last;
	logic signed [44+5:0] lim;
	logic               v_bad;
	logic signed [51:0] dx;
	logic signed [32:0] dq;
	logic signed [38:0] nr;
	logic signed [49:0] va_r, vb_r;

	ucpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept  = in_ch.valid && in_ch.ready;
	assign wr_addr = in_ch.path ? AW'(C) + AW'(in_ch.slot) : AW'(in_ch.slot);
	assign ai      = AW'(i_q);
	assign aj      = AW'(C) + AW'(j_q);
	assign abi     = AW'(bi_q);
	assign abj     = AW'(C) + AW'(bj_q);
	assign ref15   = 47'(ref_q) <<< 15;

	// shared multiplier operand selection
	always_comb begin
		mul_x = '0;
		mul_f = '0;
		unique case (st_q)
			ST_MUL_A: begin mul_x = sound_q[ai]; mul_f = factor_q[aj]; end
			ST_MUL_B: begin mul_x = sound_q[aj]; mul_f = factor_q[ai]; end
			ST_VEL_A: begin mul_x = vel_q[abi];  mul_f = factor_q[abj]; end
			ST_VEL_B: begin mul_x = vel_q[abj];  mul_f = factor_q[abi]; end
			default: ;
		endcase
	end
	assign prod = 49'(mul_x) * $signed({33'd0, mul_f});

	assign dev_abs   = dev_q[50] ? 51'(-dev_q) : 51'(dev_q);
	assign m25       = (38'(msum_q) << 4) + (38'(msum_q) << 3) + 38'(msum_q);
	assign s_now     = SW'(diff_q) + SW'(dev_abs) + (SW'(m25) << 18);
	assign pair_last = (i_q == IW'(C - 1)) && (j_q == IW'(C - 1));

	assign lim   = $signed({5'd0, max_speed_q, 14'd0});
	assign v_bad = (50'(va_q) > lim) || (50'(va_q) < -lim)
		|| (50'(vb_q) > lim) || (50'(vb_q) < -lim);
	assign va_r  = (50'(va_q) + 50'sd8192) >>> 14;
	assign vb_r  = (50'(vb_q) + 50'sd8192) >>> 14;

	// divide by 2^18 here, the divider takes the remaining factor of 125
	assign dx = 52'(dbest_q) + HALF_DIV;
	assign dq = 33'(dx >>> 18);
	assign div_req.start    = (st_q == ST_VCHK) && !v_bad;
	assign div_req.dividend = DVW'(dq + DIV_BIAS);
	assign nr = 39'(ref_q) + $signed({13'b0, div_rsp.quotient}) - QUOT_OFFSET;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (accept && in_ch.last) st_d = ST_MUL_A;
			ST_MUL_A:  st_d = ST_MUL_B;
			ST_MUL_B:  st_d = ST_ABSV;
			ST_ABSV:   st_d = ST_SCORE;
			ST_SCORE:  st_d = pair_last ? ST_CHECK : ST_MUL_A;
			ST_CHECK:  st_d = (best_q > SCORE_LIMIT) ? ST_FINISH : ST_VEL_A;
			ST_VEL_A:  st_d = ST_VEL_B;
			ST_VEL_B:  st_d = ST_VCHK;
			ST_VCHK:   st_d = v_bad ? ST_FINISH : ST_DIV;
			ST_DIV:    if (div_rsp.done) st_d = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ch.ready) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			max_speed_q <= 31'd2621440;
			ref_q       <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_FINISH && (!out_valid_q || out_ch.ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (st_q == ST_DIV && div_rsp.done) begin
				// saturate the new reference
				if (nr > 39'sd2147483647)       ref_q <= 32'sh7fffffff;
				else if (nr < -39'sd2147483648) ref_q <= 32'sh80000000;
				else                            ref_q <= 32'(nr);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_SPEED: max_speed_q <= cfg_wdata[30:0];
					REG_INIT_REF:  ref_q       <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (32'(in_ch.slot) < C)) begin
			sound_q[wr_addr]  <= in_ch.sound_term;
			factor_q[wr_addr] <= in_ch.correction_factor;
			score_q[wr_addr]  <= in_ch.match_score;
			vel_q[wr_addr]    <= in_ch.velocity;
		end
		unique case (st_q)
			ST_IDLE: begin
				i_q <= '0;
				j_q <= '0;
			end
			ST_MUL_A: a_q <= prod;
			ST_MUL_B: b_q <= prod;
			ST_ABSV: begin
				diff_q <= (a_q >= b_q) ? 51'(a_q - b_q) << 1 : 51'(b_q - a_q) << 1;
				dev_q  <= 51'(a_q) + 51'(b_q) - 51'(ref15);
				msum_q <= 33'(score_q[ai]) + 33'(score_q[aj]);
			end
			ST_SCORE: begin
				// keep the first strict minimum
				if ((i_q == '0 && j_q == '0) || s_now < best_q) begin
					best_q  <= s_now;
					bi_q    <= i_q;
					bj_q    <= j_q;
					dbest_q <= dev_q;
				end
				if (j_q == IW'(C - 1)) begin
					j_q <= '0;
					i_q <= i_q + IW'(1);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
			ST_CHECK: begin
				status_q <= STATUS_SCORE;
				vf_q     <= '0;
				vs_q     <= '0;
			end
			ST_VEL_A: va_q <= prod;
			ST_VEL_B: vb_q <= prod;
			ST_VCHK: begin
				if (v_bad) begin
					status_q <= STATUS_SPEED;
				end else begin
					status_q <= STATUS_OK;
					vf_q     <= 32'(va_r);
					vs_q     <= 32'(vb_r);
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					out_status_q <= status_q;
					out_vf_q     <= vf_q;
					out_vs_q     <= vs_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ch.ready            = (st_q == ST_IDLE);
	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = out_status_q;
	assign out_ch.velocity_first  = out_vf_q;
	assign out_ch.velocity_second = out_vs_q;

	`UCPF_ASSERT_NEXT(a_last_starts, accept && in_ch.last, st_q == ST_MUL_A, "last request did not start evaluation")
	`UCPF_ASSERT_NOW(a_fail_zero, out_valid_q && out_status_q != STATUS_OK, out_vf_q == '0 && out_vs_q == '0, "failed result carries velocities")
	`UCPF_ASSERT_NOW(a_div_state, div_rsp.done, st_q == ST_DIV, "divider finished outside its wait state")

endmodule

[sv/ucpf_div.sv]
// Divider by the constant 125 through a reciprocal multiply, with dividend and quotient registered.
// Depends on ucpf_pkg.
module ucpf_div
	import ucpf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int PW = DVW + MW;

	logic [DVW-1:0] n_q;
	logic [QW-1:0]  quot_q;
	logic           busy_q;
	logic           done_q;
	logic [PW-1:0]  prod;

	assign prod = PW'(n_q) * PW'(DIV_MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= req.start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) n_q <= req.dividend;
		if (busy_q) quot_q <= prod[DIV_SHIFT +: QW];
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule
